// ----- hdl/quad_to_oriented_box_top_assert.svh -----
// ----------------------------------------------------------------------------
// quad_to_oriented_box_top_assert.svh
// Assertion macros for the quadrilateral to oriented box block.
// ----------------------------------------------------------------------------
`ifndef QUAD_TO_ORIENTED_BOX_TOP_ASSERT_SVH
`define QUAD_TO_ORIENTED_BOX_TOP_ASSERT_SVH

// condition holds at every clock edge out of reset
`define QOB_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent in this cycle implies consequent in the next one
`define QOB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/qob_pkg.sv -----
// ----------------------------------------------------------------------------
// qob_pkg
// Types and constants for the quadrilateral to oriented box pipeline.
// ----------------------------------------------------------------------------
package qob_pkg;

  // input transaction: four corners, unsigned Q12.4
  typedef struct packed {
    logic [15:0] corner0_x;
    logic [15:0] corner0_y;
    logic [15:0] corner1_x;
    logic [15:0] corner1_y;
    logic [15:0] corner2_x;
    logic [15:0] corner2_y;
    logic [15:0] corner3_x;
    logic [15:0] corner3_y;
  } quad_t;

  // result transaction
  typedef struct packed {
    logic [15:0] mid_x;
    logic [15:0] mid_y;
    logic [16:0] box_width;
    logic [16:0] box_height;
    logic [11:0] angle_deg;
    logic        degenerate;
  } obox_t;

  // datapath widths
  localparam int LEN_SQ_W      = 34;  // dx^2 + dy^2
  localparam int LEN_W         = 17;  // rounded edge length
  localparam int OFS_W         = 19;  // corner offset from center, scaled by 4
  localparam int PROD_W        = 38;  // offset products
  localparam int DEN_W         = 39;  // determinant
  localparam int DMAG_W        = 38;  // |determinant|
  localparam int LU_W          = 20;  // ly + uy
  localparam int ALU_W         = 19;  // |ly + uy|
  localparam int NUM_W         = 37;  // |numerator|
  localparam int DREM_W        = 39;  // division remainder
  localparam int RHO_W         = 31;  // |rho|, Q1.30
  localparam int RT_IN_W       = 62;  // radicand of the sine term, padded even
  localparam int CORDIC_STAGES = 16;
  localparam int XY_W          = 34;
  localparam int Z_W           = 26;  // angle accumulator, Q.16 degrees

  localparam logic [RHO_W-1:0]     RHO_ONE    = 31'h4000_0000;
  localparam logic [60:0]          RHO_SQ_ONE = 61'h1000_0000_0000_0000;
  localparam logic signed [Z_W-1:0] ANGLE_90  = 26'sd5898240;
  localparam logic signed [Z_W-1:0] ANGLE_RND = 26'sd2048;
  localparam logic [13:0]          ANGLE_MAX  = 14'd2880;

  // atan(2^-i) in Q.16 degrees
  localparam logic signed [Z_W-1:0] ATAN_Q16 [CORDIC_STAGES] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
    26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
    26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
    26'sd917,     26'sd458,     26'sd229,    26'sd115
  };

  // sideband carried beside the edge-length square roots
  typedef struct packed {
    logic [15:0]        cx;
    logic [15:0]        cy;
    logic [DEN_W-1:0]   den;
    logic [LU_W-1:0]    lu;
  } len_side_t;

  // sideband carried beside the rho division
  typedef struct packed {
    logic [15:0]      cx;
    logic [15:0]      cy;
    logic [LEN_W-1:0] w;
    logic [LEN_W-1:0] h;
    logic             neg;
    logic             dz;
    logic             clamp;
  } div_side_t;

  // sideband carried beside the sine square root
  typedef struct packed {
    div_side_t        base;
    logic [RHO_W-1:0] mag;
  } rt_side_t;

  // sideband carried beside the CORDIC
  typedef struct packed {
    logic [15:0]      cx;
    logic [15:0]      cy;
    logic [LEN_W-1:0] w;
    logic [LEN_W-1:0] h;
    logic             dz;
    logic             flag;
  } cor_side_t;

endpackage

// ----- hdl/qob_isqrt.sv -----
// ----------------------------------------------------------------------------
// qob_isqrt
// Pipelined integer square root, one result bit per stage, with remainder.
// ----------------------------------------------------------------------------
module qob_isqrt #(
  parameter int IN_W = 34
) (
  input  logic                clk,
  input  logic                en,
  input  logic [IN_W-1:0]     rad,
  output logic [IN_W/2-1:0]   root,
  output logic [IN_W/2:0]     rem
);

  localparam int RT_W = IN_W / 2;
  localparam int RM_W = RT_W + 3;

  logic [RT_W-1:0] root_r [RT_W];
  logic [RT_W-1:0] root_nxt [RT_W];
  logic [RM_W-1:0] rem_r [RT_W];
  logic [RM_W-1:0] rem_nxt [RT_W];
  logic [IN_W-1:0] rad_r [RT_W];
  logic [IN_W-1:0] rad_nxt [RT_W];

  // one restoring step per stage: bring down two radicand bits, try root*4+1
  always_comb begin
    logic [RT_W-1:0] s_root;
    logic [RM_W-1:0] s_rem;
    logic [IN_W-1:0] s_rad;
    logic [RM_W-1:0] r_sh;
    logic [RM_W-1:0] trial;
    for (int k = 0; k < RT_W; k++) begin
      if (k == 0) begin
        s_root = '0;
        s_rem  = '0;
        s_rad  = rad;
      end else begin
        s_root = root_r[k-1];
        s_rem  = rem_r[k-1];
        s_rad  = rad_r[k-1];
      end
      r_sh  = {s_rem[RM_W-3:0], s_rad[IN_W-1 -: 2]};
      trial = {1'b0, s_root, 2'b01};
      if (r_sh >= trial) begin
        rem_nxt[k]  = r_sh - trial;
        root_nxt[k] = {s_root[RT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = r_sh;
        root_nxt[k] = {s_root[RT_W-2:0], 1'b0};
      end
      rad_nxt[k] = {s_rad[IN_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_r <= root_nxt;
      rem_r  <= rem_nxt;
      rad_r  <= rad_nxt;
    end
  end

  assign root = root_r[RT_W-1];
  assign rem  = rem_r[RT_W-1][RT_W:0];

endmodule

// ----- hdl/quad_to_oriented_box_top.sv -----
// ----------------------------------------------------------------------------
// quad_to_oriented_box_top
// Quadrilateral corners in, oriented box (center, size, angle) out.
// ----------------------------------------------------------------------------
//  channel  | direction | payload        | handshake
//  ---------+-----------+----------------+----------------------
//  in_      | input     | qob_pkg::quad_t | in_valid / in_stall
//  out_     | output    | qob_pkg::obox_t | out_valid / out_stall
//
// One quadrilateral per clock while in_stall is low.
// Depth is set by the square roots (17 and 31 stages), the 31-stage rho
// divider and the 16-stage CORDIC, each one bit or one step per stage.
// rst_n (synchronous, active low) clears all valid bits.
// A two-entry output skid keeps taking transactions while one result waits;
// the whole pipeline holds only when both skid entries are full.
// ----------------------------------------------------------------------------
module quad_to_oriented_box_top (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  qob_pkg::quad_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output qob_pkg::obox_t  out_data
);

  localparam int LEN_STG = qob_pkg::LEN_SQ_W / 2;
  localparam int DIV_STG = qob_pkg::RHO_W;
  localparam int RT_STG  = qob_pkg::RT_IN_W / 2;
  localparam int COR_STG = qob_pkg::CORDIC_STAGES;
  localparam int DEPTH   = 2 + LEN_STG + 3 + DIV_STG + 2 + RT_STG + 1 + COR_STG;

  logic adv;
  logic push;
  logic [DEPTH-1:0] vld_r;
  logic take;
  logic out_v_r, out_v_nxt, sp_v_r, sp_v_nxt;
  qob_pkg::obox_t out_d_r, out_d_nxt, sp_d_r, sp_d_nxt;

  // ---------------- valid bits ----------------
  assign adv      = !sp_v_r;
  assign in_stall = sp_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  // ---------------- stage A: sums, edge deltas, center offsets ----------------
  logic [17:0] sx_c, sy_c;
  logic [19:0] lx_c, ly_c, ux_c, uy_c;
  logic [15:0] a_cx_r, a_cy_r;
  logic signed [16:0] a_dwx_r, a_dwy_r, a_dhx_r, a_dhy_r;
  logic signed [qob_pkg::OFS_W-1:0] a_lx_r, a_ly_r, a_ux_r, a_uy_r;

  always_comb begin
    sx_c = {2'b00, in_data.corner0_x} + {2'b00, in_data.corner1_x}
         + {2'b00, in_data.corner2_x} + {2'b00, in_data.corner3_x};
    sy_c = {2'b00, in_data.corner0_y} + {2'b00, in_data.corner1_y}
         + {2'b00, in_data.corner2_y} + {2'b00, in_data.corner3_y};
    lx_c = {2'b00, in_data.corner0_x, 2'b00} - {2'b00, sx_c};
    ly_c = {2'b00, in_data.corner0_y, 2'b00} - {2'b00, sy_c};
    ux_c = {2'b00, in_data.corner3_x, 2'b00} - {2'b00, sx_c};
    uy_c = {2'b00, in_data.corner3_y, 2'b00} - {2'b00, sy_c};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_cx_r  <= sx_c[17:2];
      a_cy_r  <= sy_c[17:2];
      a_dwx_r <= $signed({1'b0, in_data.corner2_x}) - $signed({1'b0, in_data.corner1_x});
      a_dwy_r <= $signed({1'b0, in_data.corner2_y}) - $signed({1'b0, in_data.corner1_y});
      a_dhx_r <= $signed({1'b0, in_data.corner1_x}) - $signed({1'b0, in_data.corner0_x});
      a_dhy_r <= $signed({1'b0, in_data.corner1_y}) - $signed({1'b0, in_data.corner0_y});
      a_lx_r  <= $signed(lx_c[qob_pkg::OFS_W-1:0]);
      a_ly_r  <= $signed(ly_c[qob_pkg::OFS_W-1:0]);
      a_ux_r  <= $signed(ux_c[qob_pkg::OFS_W-1:0]);
      a_uy_r  <= $signed(uy_c[qob_pkg::OFS_W-1:0]);
    end
  end

  // ---------------- stage B: squares and determinant products ----------------
  logic signed [33:0] sq_wx, sq_wy, sq_hx, sq_hy;
  logic signed [qob_pkg::PROD_W-1:0] p1_c, p2_c;
  logic signed [qob_pkg::LU_W-1:0] lu_c;
  logic [15:0] b_cx_r, b_cy_r;
  logic [qob_pkg::LEN_SQ_W-1:0] b_sqw_r, b_sqh_r;
  logic signed [qob_pkg::PROD_W-1:0] b_p1_r, b_p2_r;
  logic signed [qob_pkg::LU_W-1:0] b_lu_r;

  always_comb begin
    sq_wx = a_dwx_r * a_dwx_r;
    sq_wy = a_dwy_r * a_dwy_r;
    sq_hx = a_dhx_r * a_dhx_r;
    sq_hy = a_dhy_r * a_dhy_r;
    p1_c  = a_lx_r * a_uy_r;
    p2_c  = a_ux_r * a_ly_r;
    lu_c  = a_ly_r + a_uy_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_cx_r  <= a_cx_r;
      b_cy_r  <= a_cy_r;
      b_sqw_r <= $unsigned(sq_wx) + $unsigned(sq_wy);
      b_sqh_r <= $unsigned(sq_hx) + $unsigned(sq_hy);
      b_p1_r  <= p1_c;
      b_p2_r  <= p2_c;
      b_lu_r  <= lu_c;
    end
  end

  // ---------------- edge-length square roots ----------------
  logic [LEN_STG-1:0] w_root, h_root;
  logic [LEN_STG:0]   w_rem, h_rem;
  logic signed [qob_pkg::DEN_W-1:0] den_c;
  qob_pkg::len_side_t ls_r [LEN_STG];
  qob_pkg::len_side_t ls_nxt [LEN_STG];

  qob_isqrt #(.IN_W(qob_pkg::LEN_SQ_W)) u_len_w (
    .clk(clk), .en(adv), .rad(b_sqw_r), .root(w_root), .rem(w_rem)
  );
  qob_isqrt #(.IN_W(qob_pkg::LEN_SQ_W)) u_len_h (
    .clk(clk), .en(adv), .rad(b_sqh_r), .root(h_root), .rem(h_rem)
  );

  // determinant formed in the first sideband slot
  always_comb begin
    den_c = b_p1_r - b_p2_r;
    for (int k = 0; k < LEN_STG; k++) begin
      if (k == 0) begin
        ls_nxt[k] = '{cx: b_cx_r, cy: b_cy_r, den: den_c, lu: b_lu_r};
      end else begin
        ls_nxt[k] = ls_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ls_r <= ls_nxt;
    end
  end

  // ---------------- stage R: round lengths, magnitudes ----------------
  qob_pkg::len_side_t ls_end;
  logic signed [qob_pkg::LU_W-1:0]  lu_s, lu_n;
  logic signed [qob_pkg::DEN_W-1:0] den_s, den_n;
  logic [15:0] r_cx_r, r_cy_r;
  logic [qob_pkg::LEN_W-1:0] r_w_r, r_h_r;
  logic [qob_pkg::ALU_W-1:0] r_alu_r;
  logic r_lupos_r, r_dneg_r, r_dz_r;
  logic [qob_pkg::DMAG_W-1:0] r_mden_r;

  always_comb begin
    ls_end = ls_r[LEN_STG-1];
    lu_s   = $signed(ls_end.lu);
    lu_n   = -lu_s;
    den_s  = $signed(ls_end.den);
    den_n  = -den_s;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_cx_r    <= ls_end.cx;
      r_cy_r    <= ls_end.cy;
      r_w_r     <= (w_rem > {1'b0, w_root}) ? w_root + 17'd1 : w_root;
      r_h_r     <= (h_rem > {1'b0, h_root}) ? h_root + 17'd1 : h_root;
      r_alu_r   <= lu_s[qob_pkg::LU_W-1] ? lu_n[qob_pkg::ALU_W-1:0]
                                         : lu_s[qob_pkg::ALU_W-1:0];
      r_lupos_r <= !lu_s[qob_pkg::LU_W-1] && (lu_s != '0);
      r_dneg_r  <= den_s[qob_pkg::DEN_W-1];
      r_dz_r    <= (den_s == '0);
      r_mden_r  <= den_s[qob_pkg::DEN_W-1] ? den_n[qob_pkg::DMAG_W-1:0]
                                           : den_s[qob_pkg::DMAG_W-1:0];
    end
  end

  // ---------------- stage M: numerator magnitude and quotient sign ----------------
  logic [35:0] wlu_c;
  logic [15:0] m_cx_r, m_cy_r;
  logic [qob_pkg::LEN_W-1:0] m_w_r, m_h_r;
  logic [qob_pkg::NUM_W-1:0] m_mnum_r;
  logic [qob_pkg::DMAG_W-1:0] m_mden_r;
  logic m_neg_r, m_dz_r;

  assign wlu_c = r_w_r * r_alu_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      m_cx_r   <= r_cx_r;
      m_cy_r   <= r_cy_r;
      m_w_r    <= r_w_r;
      m_h_r    <= r_h_r;
      m_mnum_r <= {wlu_c, 1'b0};
      m_mden_r <= r_mden_r;
      m_neg_r  <= ((r_w_r != '0) && r_lupos_r) != r_dneg_r;
      m_dz_r   <= r_dz_r;
    end
  end

  // ---------------- stage Q: range check ----------------
  qob_pkg::div_side_t q_side_r;
  logic [qob_pkg::NUM_W-1:0]  q_mnum_r;
  logic [qob_pkg::DMAG_W-1:0] q_mden_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      q_side_r <= '{cx: m_cx_r, cy: m_cy_r, w: m_w_r, h: m_h_r, neg: m_neg_r,
                    dz: m_dz_r, clamp: ({1'b0, m_mnum_r} > m_mden_r)};
      q_mnum_r <= m_mnum_r;
      q_mden_r <= m_mden_r;
    end
  end

  // ---------------- rho divider: one quotient bit per stage ----------------
  logic [qob_pkg::DREM_W-1:0] dr_r [DIV_STG];
  logic [qob_pkg::DREM_W-1:0] dr_nxt [DIV_STG];
  logic [qob_pkg::RHO_W-1:0]  dq_r [DIV_STG];
  logic [qob_pkg::RHO_W-1:0]  dq_nxt [DIV_STG];
  logic [qob_pkg::DMAG_W-1:0] dd_r [DIV_STG];
  logic [qob_pkg::DMAG_W-1:0] dd_nxt [DIV_STG];
  qob_pkg::div_side_t ds_r [DIV_STG];
  qob_pkg::div_side_t ds_nxt [DIV_STG];

  always_comb begin
    logic [qob_pkg::DREM_W-1:0] s_r;
    logic [qob_pkg::DREM_W-1:0] r_sh;
    logic [qob_pkg::RHO_W-1:0]  s_q;
    logic [qob_pkg::DMAG_W-1:0] s_d;
    logic ge;
    for (int k = 0; k < DIV_STG; k++) begin
      if (k == 0) begin
        s_r       = {2'b00, q_mnum_r};
        s_q       = '0;
        s_d       = q_mden_r;
        ds_nxt[k] = q_side_r;
        r_sh      = s_r;
      end else begin
        s_r       = dr_r[k-1];
        s_q       = dq_r[k-1];
        s_d       = dd_r[k-1];
        ds_nxt[k] = ds_r[k-1];
        r_sh      = {s_r[qob_pkg::DREM_W-2:0], 1'b0};
      end
      ge        = (r_sh >= {1'b0, s_d});
      dr_nxt[k] = ge ? r_sh - {1'b0, s_d} : r_sh;
      dq_nxt[k] = {s_q[qob_pkg::RHO_W-2:0], ge};
      dd_nxt[k] = s_d;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dr_r <= dr_nxt;
      dq_r <= dq_nxt;
      dd_r <= dd_nxt;
      ds_r <= ds_nxt;
    end
  end

  // ---------------- stage P: clamp and square rho ----------------
  qob_pkg::div_side_t ds_end;
  logic [qob_pkg::RHO_W-1:0] mag_c;
  logic [61:0] msq_c;
  qob_pkg::rt_side_t p_side_r;
  logic [61:0] p_msq_r;

  always_comb begin
    ds_end = ds_r[DIV_STG-1];
    mag_c  = ds_end.clamp ? qob_pkg::RHO_ONE : dq_r[DIV_STG-1];
    msq_c  = mag_c * mag_c;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_side_r <= '{base: ds_end, mag: mag_c};
      p_msq_r  <= msq_c;
    end
  end

  // ---------------- stage U: 1 - rho^2 ----------------
  qob_pkg::rt_side_t u_side_r;
  logic [qob_pkg::RT_IN_W-1:0] u_rad_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      u_side_r <= p_side_r;
      u_rad_r  <= {1'b0, qob_pkg::RHO_SQ_ONE - p_msq_r[60:0]};
    end
  end

  // ---------------- sine square root ----------------
  logic [RT_STG-1:0] s_root;
  logic [RT_STG:0]   s_rem;   // truncated root, remainder not needed
  qob_pkg::rt_side_t rs_r [RT_STG];
  qob_pkg::rt_side_t rs_nxt [RT_STG];

  qob_isqrt #(.IN_W(qob_pkg::RT_IN_W)) u_rho_sqrt (
    .clk(clk), .en(adv), .rad(u_rad_r), .root(s_root), .rem(s_rem)
  );

  always_comb begin
    for (int k = 0; k < RT_STG; k++) begin
      if (k == 0) begin
        rs_nxt[k] = u_side_r;
      end else begin
        rs_nxt[k] = rs_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rs_r <= rs_nxt;
    end
  end

  // ---------------- stage X: quarter turn for negative rho ----------------
  qob_pkg::rt_side_t rs_end;
  logic prerot;
  logic signed [qob_pkg::XY_W-1:0] x0_r, y0_r;
  logic signed [qob_pkg::Z_W-1:0]  z0_r;
  qob_pkg::cor_side_t x0_side_r;

  always_comb begin
    rs_end = rs_r[RT_STG-1];
    prerot = rs_end.base.neg && (rs_end.mag != '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x0_r <= $signed({3'b000, prerot ? s_root : rs_end.mag});
      y0_r <= $signed({3'b000, prerot ? rs_end.mag : s_root});
      z0_r <= prerot ? qob_pkg::ANGLE_90 : '0;
      x0_side_r <= '{cx: rs_end.base.cx, cy: rs_end.base.cy, w: rs_end.base.w,
                     h: rs_end.base.h, dz: rs_end.base.dz,
                     flag: rs_end.base.dz || rs_end.base.clamp};
    end
  end

  // ---------------- CORDIC, vectoring mode ----------------
  logic signed [qob_pkg::XY_W-1:0] kx_r [COR_STG];
  logic signed [qob_pkg::XY_W-1:0] kx_nxt [COR_STG];
  logic signed [qob_pkg::XY_W-1:0] ky_r [COR_STG];
  logic signed [qob_pkg::XY_W-1:0] ky_nxt [COR_STG];
  logic signed [qob_pkg::Z_W-1:0]  kz_r [COR_STG];
  logic signed [qob_pkg::Z_W-1:0]  kz_nxt [COR_STG];
  qob_pkg::cor_side_t ks_r [COR_STG];
  qob_pkg::cor_side_t ks_nxt [COR_STG];

  always_comb begin
    logic signed [qob_pkg::XY_W-1:0] s_x, s_y, dx, dy;
    logic signed [qob_pkg::Z_W-1:0]  s_z;
    for (int k = 0; k < COR_STG; k++) begin
      if (k == 0) begin
        s_x       = x0_r;
        s_y       = y0_r;
        s_z       = z0_r;
        ks_nxt[k] = x0_side_r;
      end else begin
        s_x       = kx_r[k-1];
        s_y       = ky_r[k-1];
        s_z       = kz_r[k-1];
        ks_nxt[k] = ks_r[k-1];
      end
      dx = s_x >>> k;
      dy = s_y >>> k;
      if (!s_y[qob_pkg::XY_W-1]) begin
        kx_nxt[k] = s_x + dy;
        ky_nxt[k] = s_y - dx;
        kz_nxt[k] = s_z + qob_pkg::ATAN_Q16[k];
      end else begin
        kx_nxt[k] = s_x - dy;
        ky_nxt[k] = s_y + dx;
        kz_nxt[k] = s_z - qob_pkg::ATAN_Q16[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kx_r <= kx_nxt;
      ky_r <= ky_nxt;
      kz_r <= kz_nxt;
      ks_r <= ks_nxt;
    end
  end

  // ---------------- result: round angle to Q.4 and clamp ----------------
  qob_pkg::cor_side_t ks_end;
  logic signed [qob_pkg::Z_W-1:0] z_end, z_rnd;
  logic [13:0] ang_q;
  logic [11:0] ang_c;
  qob_pkg::obox_t fin;

  always_comb begin
    ks_end = ks_r[COR_STG-1];
    z_end  = kz_r[COR_STG-1];
    z_rnd  = z_end + qob_pkg::ANGLE_RND;
    ang_q  = z_rnd[qob_pkg::Z_W-1:12];
    if (ks_end.dz || z_end[qob_pkg::Z_W-1]) begin
      ang_c = '0;
    end else if (ang_q > qob_pkg::ANGLE_MAX) begin
      ang_c = qob_pkg::ANGLE_MAX[11:0];
    end else begin
      ang_c = ang_q[11:0];
    end
    fin = '{mid_x: ks_end.cx, mid_y: ks_end.cy, box_width: ks_end.w,
            box_height: ks_end.h, angle_deg: ang_c, degenerate: ks_end.flag};
  end

  // ---------------- output skid ----------------
  assign push = adv && vld_r[DEPTH-1];
  assign take = out_v_r && !out_stall;

  always_comb begin
    out_v_nxt = out_v_r;
    out_d_nxt = out_d_r;
    sp_v_nxt  = sp_v_r;
    sp_d_nxt  = sp_d_r;
    if (!out_v_r || take) begin
      if (sp_v_r) begin
        out_v_nxt = 1'b1;
        out_d_nxt = sp_d_r;
        sp_v_nxt  = 1'b0;
      end else begin
        out_v_nxt = push;
        out_d_nxt = fin;
      end
    end else if (push) begin
      sp_v_nxt = 1'b1;
      sp_d_nxt = fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sp_v_r  <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      sp_v_r  <= sp_v_nxt;
    end
    out_d_r <= out_d_nxt;
    sp_d_r  <= sp_d_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  // ---------------- assertions ----------------
  `include "quad_to_oriented_box_top_assert.svh"

  `QOB_ASSERT_ALWAYS(a_spare_needs_out, !sp_v_r || out_v_r, "skid spare full while output empty")
  `QOB_ASSERT_NEXT(a_hold_when_full, sp_v_r, $stable(vld_r), "pipeline moved while skid full")
  `QOB_ASSERT_NEXT(a_push_to_spare, out_v_r && out_stall && push, sp_v_r, "result lost at skid")
  `QOB_ASSERT_ALWAYS(a_angle_range, !out_v_r || (out_d_r.angle_deg <= 12'd2880), "angle out of range")

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for quad_to_oriented_box_top: directed corner cases from
// a stimulus table, then random quadrilaterals, each result compared field by
// field with a typed-in result or an in-bench fixed-point model of the box conversion.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM   = 1250;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYC  = 150;

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_stall;
  qob_pkg::quad_t  in_data;
  logic   out_valid;
  logic   out_stall;
  qob_pkg::obox_t  out_data;

  qob_pkg::obox_t  box_queue[$];
  int     err_cnt = 0;
  int     idle_cnt;
  bit     quiet_mode;   // no idling in the last part of the run
  bit     hold_out;     // long receiver hold-off request

  quad_to_oriented_box_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // box model
  // ---------------------------------------------------------------------------
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned edge_len(longint dx, longint dy);
    longint unsigned s, r;
    s = longint'(dx * dx) + longint'(dy * dy);
    r = int_sqrt(s);
    if (s - r * r > r) r++;
    return r;
  endfunction

  // floor shift
  function automatic longint shr_floor(longint v, int sh);
    return v >>> sh;
  endfunction

  function automatic longint unsigned angle_of(longint x, longint y);
    longint z, dx, dy, t;
    longint unsigned q;
    z = 0;
    if (x < 0) begin
      t = x; x = y; y = -t;
      z = longint'(qob_pkg::ANGLE_90);
    end
    for (int i = 0; i < qob_pkg::CORDIC_STAGES; i++) begin
      dx = shr_floor(x, i);
      dy = shr_floor(y, i);
      if (y >= 0) begin
        x += dy; y -= dx; z += longint'(qob_pkg::ATAN_Q16[i]);
      end else begin
        x -= dy; y += dx; z -= longint'(qob_pkg::ATAN_Q16[i]);
      end
    end
    if (z < 0) return 0;
    q = (longint'(z) + 2048) >> 12;
    return (q > 2880) ? 2880 : q;
  endfunction

  function automatic qob_pkg::obox_t box_of(qob_pkg::quad_t q);
    qob_pkg::obox_t b;
    longint px[4], py[4];
    longint sx, sy, lx, ly, ux, uy, num, den;
    longint unsigned w, h, mnum, mden, mag, r, s, ang;
    bit flag, neg;
    px[0] = q.corner0_x; py[0] = q.corner0_y;
    px[1] = q.corner1_x; py[1] = q.corner1_y;
    px[2] = q.corner2_x; py[2] = q.corner2_y;
    px[3] = q.corner3_x; py[3] = q.corner3_y;
    sx = px[0] + px[1] + px[2] + px[3];
    sy = py[0] + py[1] + py[2] + py[3];
    w = edge_len(px[2] - px[1], py[2] - py[1]);
    h = edge_len(px[1] - px[0], py[1] - py[0]);
    lx = 4 * px[0] - sx; ly = 4 * py[0] - sy;
    ux = 4 * px[3] - sx; uy = 4 * py[3] - sy;
    den = lx * uy - ux * ly;
    num = -2 * longint'(w) * (ly + uy);
    flag = 1'b0;
    ang = 0;
    if (den == 0) begin
      flag = 1'b1;
    end else begin
      neg = (num < 0) != (den < 0);
      mnum = (num < 0) ? -num : num;
      mden = (den < 0) ? -den : den;
      if (mnum > mden) begin
        flag = 1'b1;
        mag = 64'd1 << 30;
      end else begin
        mag = 0; r = mnum;
        if (r >= mden) begin mag = 1; r -= mden; end
        for (int i = 0; i < 30; i++) begin
          r <<= 1; mag <<= 1;
          if (r >= mden) begin mag |= 1; r -= mden; end
        end
      end
      s = int_sqrt((64'd1 << 60) - mag * mag);
      ang = angle_of(neg ? -longint'(mag) : longint'(mag), longint'(s));
    end
    b.mid_x      = 16'(sx >> 2);
    b.mid_y      = 16'(sy >> 2);
    b.box_width  = 17'(w);
    b.box_height = 17'(h);
    b.angle_deg  = 12'(ang);
    b.degenerate = flag;
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // directed table: quad and, where obvious, the typed-in result
  // ---------------------------------------------------------------------------
  typedef struct {
    qob_pkg::quad_t q;
    bit    typed;
    qob_pkg::obox_t b;
  } dir_row_t;

  localparam int N_DIR = 10;
  dir_row_t dir_tab[N_DIR];

  initial begin
    // all corners at origin: zero determinant
    dir_tab[0] = '{q: '0, typed: 1, b: '{0, 0, 0, 0, 0, 1}};
    // all corners at max
    dir_tab[1] = '{q: {8{16'hFFFF}}, typed: 1, b: '{16'hFFFF, 16'hFFFF, 0, 0, 0, 1}};
    // axis-aligned square 16x16 px
    dir_tab[2] = '{q: {16'd0, 16'd0, 16'd0, 16'd256, 16'd256, 16'd256,
                       16'd256, 16'd0}, typed: 0, b: '0};
    // corners 1 and 2 coincide: angle 90
    dir_tab[3] = '{q: {16'd0, 16'd0, 16'd100, 16'd0, 16'd100, 16'd0,
                       16'd0, 16'd100}, typed: 0, b: '0};
    // extreme square spanning the whole range
    dir_tab[4] = '{q: {16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF,
                       16'hFFFF, 16'hFFFF, 16'h0000}, typed: 0, b: '0};
    // rotated square, opposite winding
    dir_tab[5] = '{q: {16'd256, 16'd0, 16'd0, 16'd0, 16'd0, 16'd256,
                       16'd256, 16'd256}, typed: 0, b: '0};
    // diamond
    dir_tab[6] = '{q: {16'd500, 16'd0, 16'd1000, 16'd500, 16'd500, 16'd1000,
                       16'd0, 16'd500}, typed: 0, b: '0};
    // skewed quad: small argument, no clamp
    dir_tab[7] = '{q: {16'd0, 16'd0, 16'd4000, 16'd0, 16'd4000, 16'd10,
                       16'd0, 16'd5}, typed: 0, b: '0};
    // collinear corners: zero determinant
    dir_tab[8] = '{q: {16'd0, 16'd0, 16'd10, 16'd10, 16'd20, 16'd20,
                       16'd30, 16'd30}, typed: 0, b: '0};
    // alternating bit patterns
    dir_tab[9] = '{q: {16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'hFFFF,
                       16'h0001, 16'h8000, 16'h7FFF}, typed: 0, b: '0};
  end

  function automatic qob_pkg::quad_t rand_quad();
    qob_pkg::quad_t q;
    int unsigned cx, cy, hw, hh, rng;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      q = {$urandom, $urandom, $urandom, $urandom};
    end else begin
      // near-rectangular quad with jitter, random scale
      rng = (kind == 9) ? 32000 : (1 << $urandom_range(4, 13));
      cx = $urandom_range(rng, 65535 - rng);
      cy = $urandom_range(rng, 65535 - rng);
      hw = $urandom_range(0, rng);
      hh = $urandom_range(0, rng);
      q.corner0_x = 16'(cx - hw + $urandom_range(0, 3));
      q.corner0_y = 16'(cy - hh + $urandom_range(0, 3));
      q.corner1_x = 16'(cx - hw + $urandom_range(0, 3));
      q.corner1_y = 16'(cy + hh - $urandom_range(0, 3));
      q.corner2_x = 16'(cx + hw - $urandom_range(0, 3));
      q.corner2_y = 16'(cy + hh - $urandom_range(0, 3));
      q.corner3_x = 16'(cx + hw - $urandom_range(0, 3));
      q.corner3_y = 16'(cy - hh + $urandom_range(0, 3));
      if (kind == 8) q = {q[63:0], q[127:64]};
    end
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------
  task automatic send_quad(qob_pkg::quad_t q, bit typed, qob_pkg::obox_t b);
    if (!quiet_mode && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    box_queue.insert(box_queue.size(), typed ? b : box_of(q));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (box_queue.size() != 0) @(posedge clk);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    quiet_mode = 1'b0;
    hold_out  = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++)
      send_quad(dir_tab[i].q, dir_tab[i].typed, dir_tab[i].b);
    // sender pause until all results are back
    wait_drained();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) hold_out <= 1'b1;
      if (i == 600) begin
        wait_drained();
        @(posedge clk);
      end
      if (i == N_RANDOM - 200) quiet_mode <= 1'b1;
      send_quad(rand_quad(), 1'b0, '0);
    end
    in_valid <= 1'b0;
    while (box_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (err_cnt == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall bursts plus one long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int n;
    bit held;
    out_stall = 1'b0;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_out && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 4);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result check
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    qob_pkg::obox_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (box_queue.size() == 0) begin
        $error("result transaction with nothing expected");
        err_cnt++;
      end else begin
        e = box_queue.pop_front();
        if (out_data.mid_x !== e.mid_x) begin
          $error("mid_x exp %0d got %0d", e.mid_x, out_data.mid_x); err_cnt++;
        end
        if (out_data.mid_y !== e.mid_y) begin
          $error("mid_y exp %0d got %0d", e.mid_y, out_data.mid_y); err_cnt++;
        end
        if (out_data.box_width !== e.box_width) begin
          $error("box_width exp %0d got %0d", e.box_width, out_data.box_width); err_cnt++;
        end
        if (out_data.box_height !== e.box_height) begin
          $error("box_height exp %0d got %0d", e.box_height, out_data.box_height);
          err_cnt++;
        end
        if (out_data.angle_deg !== e.angle_deg) begin
          $error("angle_deg exp %0d got %0d", e.angle_deg, out_data.angle_deg); err_cnt++;
        end
        if (out_data.degenerate !== e.degenerate) begin
          $error("degenerate exp %0d got %0d", e.degenerate, out_data.degenerate);
          err_cnt++;
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt > IDLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/qob_pkg.sv
hdl/qob_isqrt.sv
hdl/quad_to_oriented_box_top.sv
tb/testbench.sv
